// File: rtl/iplpr_pkg.sv
// Package for the IPv4 longest-prefix route table core.
// Holds opcodes, slot record type and the prefix-length function; no dependencies.
`timescale 1ns / 1ps
package iplpr_pkg;
  localparam int DefaultSlots = 64;

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_DELDEV = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [31:0] metric;
    logic [7:0]  device;
  } route_t;

  // leading one-bits of a mask: 31 minus the position of the highest zero bit, or 32 if none
  function automatic logic [5:0] ones_prefix(input logic [31:0] m);
    logic [5:0] n;
    n = 6'd32;
    for (int k = 0; k < 32; k++) begin
      if (!m[k]) n = 6'(31 - k);
    end
    return n;
  endfunction
endpackage

// File: rtl/ipv4_longest_prefix_route_table_core.sv
// IPv4 longest-prefix route table core: slot records in one synchronous memory.
// Depends on iplpr_pkg.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  in      | in_valid  | in_stall  | opcode address mask next_hop cost device_id
//  out     | out_valid | out_stall | status found hit_* removed_count
//
// Flow: every opcode takes the same path. The scan issues one memory read per
// slot below the scan bound, then drains the last read; delete stops reading at
// its hit. Then a write step, a trim step that drops dead slots off the top of
// the bound, and a step that loads the result. Delete by device that frees
// slots at the top lengthens the trim. A new word is taken only once the
// previous result is loaded.
// Reset clears live bits, scan bound and live count; slot records stay
// undefined until written. A stalled result holds; the next word runs up to
// the trim step and waits there.
`timescale 1ns / 1ps
module ipv4_longest_prefix_route_table_core #(
  parameter int TABLE_SLOTS = iplpr_pkg::DefaultSlots
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [31:0] address,
  input  logic [31:0] mask,
  input  logic [31:0] next_hop,
  input  logic [31:0] cost,
  input  logic [7:0]  device_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic        found,
  output logic [31:0] hit_dest,
  output logic [31:0] hit_mask,
  output logic [31:0] hit_gateway,
  output logic [31:0] hit_metric,
  output logic [7:0]  hit_device,
  output logic [5:0]  hit_prefix,
  output logic [6:0]  removed_count
);
  import iplpr_pkg::*;

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_SHRNK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  route_t             mem [TABLE_SLOTS];
  route_t             rd_data;
  logic [TABLE_SLOTS-1:0] live;
  logic [CW-1:0]      scan_bound, live_total;

  logic [2:0]  state;
  logic [2:0]  op;
  route_t      req;
  logic [CW-1:0] rd_idx;      // next slot to issue
  logic        rd_vld;        // read data valid this cycle
  logic [IW-1:0] rd_slot;     // slot of rd_data
  logic        have;
  logic [5:0]  best_len;
  route_t      best_rec;
  logic        hit;           // delete target found
  logic [IW-1:0] tgt;         // slot to write or free
  logic        tgt_ok;
  logic [CW-1:0] freed;

  logic        wr_en;
  logic [IW-1:0] wr_addr;
  route_t      wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_idx[IW-1:0]];
  end

  logic issue;
  assign issue = (state == S_SCAN) && (rd_idx < scan_bound)
                 && !(op == OP_DELETE && hit);

  // comparison stage on the registered read data
  logic       r_live, r_match;
  logic [5:0] r_len;
  assign r_live  = rd_vld && live[rd_slot];
  assign r_match = ((req.dest & rd_data.mask) == (rd_data.dest & rd_data.mask));
  assign r_len   = ones_prefix(rd_data.mask);

  // lookup that found a route
  logic lk_hit;
  assign lk_hit = (op == OP_LOOKUP) && have;

  // lowest free slot for add, from the live bits; runs during the scan
  logic [IW-1:0] free_idx;
  logic          free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int k = TABLE_SLOTS - 1; k >= 0; k--) begin
      if (!live[k]) begin
        free_idx = IW'(k);
        free_any = 1'b1;
      end
    end
  end

  assign in_stall = (state != S_IDLE);

  assign wr_en   = (state == S_WRITE) && (op == OP_ADD) && tgt_ok;
  assign wr_addr = tgt;
  assign wr_data = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live       <= '0;
      scan_bound <= '0;
      live_total <= '0;
      out_valid  <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      rd_vld <= issue;
      rd_slot <= rd_idx[IW-1:0];
      if (issue) rd_idx <= rd_idx + 1'b1;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op          <= opcode;
            req.dest    <= address;
            req.mask    <= mask;
            req.gateway <= next_hop;
            req.metric  <= cost;
            req.device  <= device_id;
            rd_idx      <= '0;
            have        <= 1'b0;
            hit         <= 1'b0;
            freed       <= '0;
            best_len    <= '0;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          // pick the add target while the live bits are steady
          if (op == OP_ADD) begin
            tgt    <= free_idx;
            tgt_ok <= free_any && (live_total < CW'(TABLE_SLOTS));
          end
          // evaluate returning slot
          if (r_live) begin
            case (op)
              OP_LOOKUP: begin
                if (r_match && (!have || r_len > best_len ||
                    (r_len == best_len && rd_data.metric < best_rec.metric))) begin
                  have     <= 1'b1;
                  best_len <= r_len;
                  best_rec <= rd_data;
                end
              end
              OP_DELETE: begin
                if (!hit && rd_data.dest == req.dest && rd_data.mask == req.mask) begin
                  hit <= 1'b1;
                  tgt <= rd_slot;
                end
              end
              OP_DELDEV: begin
                if (req.device != 8'd0 && rd_data.device == req.device) begin
                  live[rd_slot] <= 1'b0;
                  freed         <= freed + 1'b1;
                end
              end
              default: ;
            endcase
          end
          if (!issue && !rd_vld) state <= S_WRITE;
        end
        S_WRITE: begin
          state <= S_SHRNK;
          case (op)
            OP_ADD: begin
              if (tgt_ok) begin
                live[tgt]  <= 1'b1;
                live_total <= live_total + 1'b1;
                if ({1'b0, tgt} >= {1'b0, scan_bound})
                  scan_bound <= CW'({1'b0, tgt} + 1);
              end
            end
            OP_DELETE: begin
              if (hit) begin
                live[tgt]  <= 1'b0;
                live_total <= live_total - 1'b1;
              end
            end
            OP_DELDEV: live_total <= live_total - freed;
            OP_CLEAR: begin
              live       <= '0;
              scan_bound <= '0;
              live_total <= '0;
            end
            default: ;
          endcase
        end
        S_SHRNK: begin
          // drop the bound one dead slot per cycle
          if (scan_bound != '0 && !live[scan_bound[IW-1:0] - 1'b1]
              && !(scan_bound == CW'(TABLE_SLOTS) && 1'b0))
            scan_bound <= scan_bound - 1'b1;
          else if (!out_valid || !out_stall) state <= S_DONE;
        end
        S_DONE: begin
          out_valid     <= 1'b1;
          found         <= lk_hit;
          hit_dest      <= lk_hit ? best_rec.dest : '0;
          hit_mask      <= lk_hit ? best_rec.mask : '0;
          hit_gateway   <= lk_hit ? best_rec.gateway : '0;
          hit_metric    <= lk_hit ? best_rec.metric : '0;
          hit_device    <= lk_hit ? best_rec.device : '0;
          hit_prefix    <= lk_hit ? best_len : '0;
          removed_count <= (op == OP_DELDEV) ? 7'(freed) : '0;
          case (op)
            OP_LOOKUP: status <= !have;
            OP_ADD:    status <= !tgt_ok;
            OP_DELETE: status <= !hit;
            OP_DELDEV: status <= 1'b0;
            OP_CLEAR:  status <= 1'b0;
            default:   status <= 1'b1;
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a held result must not change under stall
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit_dest) && $stable(status))
    else $error("result changed while stalled");
  // live count matches live bits once idle
  assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> $countones(live) == int'(live_total))
    else $error("live count out of step");
  // no word accepted while busy
  assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall)
    else $error("input taken while busy");
endmodule
